// ===== rtl/i2cseq_pkg.sv =====
// Shared types and constants for the I2C interrupt-driven transfer sequencer.
package i2cseq_pkg;

    localparam int LENGTH_BITS = 16;

    typedef logic [LENGTH_BITS-1:0] len_t;

    // Request kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_BEGIN_TX = 2'd0,
        REQ_BEGIN_RX = 2'd1,
        REQ_EVENT    = 2'd2,
        REQ_ERROR    = 2'd3
    } req_kind_t;

    // Transfer state, one-hot
    typedef enum logic [2:0] {
        ST_READY   = 3'b001,
        ST_BUSY_RX = 3'b010,
        ST_BUSY_TX = 3'b100
    } xfer_state_t;

    // Reported state codes
    localparam logic [1:0] PRIOR_READY   = 2'd0;
    localparam logic [1:0] PRIOR_BUSY_RX = 2'd1;
    localparam logic [1:0] PRIOR_BUSY_TX = 2'd2;

    // Status flag bit positions
    localparam int FLAG_SB    = 0;
    localparam int FLAG_ADDR  = 1;
    localparam int FLAG_BTF   = 2;
    localparam int FLAG_STOPF = 3;
    localparam int FLAG_TXE   = 4;
    localparam int FLAG_RXNE  = 5;

    // Notification bit positions
    localparam int NOTE_TX_DONE  = 0;
    localparam int NOTE_RX_DONE  = 1;
    localparam int NOTE_STOP     = 2;
    localparam int NOTE_SLV_SEND = 3;
    localparam int NOTE_SLV_RECV = 4;

    typedef struct packed {
        req_kind_t   req_type;
        logic [15:0] transfer_length;
        logic [6:0]  target_address;
        logic        repeated_start;
        logic [5:0]  flag_bits;
        logic        is_master;
        logic        is_transmitter;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] prior_status;
        logic       start_issued;
        logic       data_write;
        logic [7:0] data_value;
        logic       tx_taken;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       ack_level;
        logic       stop_issued;
        logic [4:0] notify_mask;
        logic [4:0] error_mask;
    } result_t;

endpackage

// ===== rtl/i2cseq_in_stage.sv =====
// Input register stage holding one accepted request.
module i2cseq_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cseq_pkg::req_t    in_req,
    input  logic                advance,
    output logic                req_valid,
    output i2cseq_pkg::req_t    req_q
);
    import i2cseq_pkg::*;

    logic valid_reg, valid_next;
    req_t req_reg;

    assign s_ready   = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req_q     = req_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= in_req;
        end
    end

endmodule

// ===== rtl/i2cseq_core.sv =====
// Transfer state registers and per-request sequencing logic.
module i2cseq_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 advance,
    input  i2cseq_pkg::req_t     req,
    output i2cseq_pkg::result_t  res
);
    import i2cseq_pkg::*;

    xfer_state_t state_reg, state_next;
    logic [6:0]  peer_reg, peer_next;
    len_t        tx_rem_reg, tx_rem_next;
    len_t        rx_rem_reg, rx_rem_next;
    len_t        rx_tot_reg, rx_tot_next;
    logic        hold_reg, hold_next;
    logic        irq_reg, irq_next;
    logic        ack_reg, ack_next;
    logic        ack_restore_reg;

    always_comb begin
        logic busy;
        logic [5:0] fl;

        busy = (state_reg != ST_READY);
        fl   = req.flag_bits;

        state_next  = state_reg;
        peer_next   = peer_reg;
        tx_rem_next = tx_rem_reg;
        rx_rem_next = rx_rem_reg;
        rx_tot_next = rx_tot_reg;
        hold_next   = hold_reg;
        irq_next    = irq_reg;
        ack_next    = ack_reg;
        res         = '0;

        unique case (state_reg)
            ST_BUSY_RX: res.prior_status = PRIOR_BUSY_RX;
            ST_BUSY_TX: res.prior_status = PRIOR_BUSY_TX;
            default:    res.prior_status = PRIOR_READY;
        endcase

        unique case (req.req_type)
            REQ_BEGIN_TX, REQ_BEGIN_RX: begin
                if (!busy) begin
                    if (req.req_type == REQ_BEGIN_TX) begin
                        state_next  = ST_BUSY_TX;
                        tx_rem_next = len_t'(req.transfer_length);
                    end else begin
                        state_next  = ST_BUSY_RX;
                        rx_rem_next = len_t'(req.transfer_length);
                        rx_tot_next = len_t'(req.transfer_length);
                    end
                    peer_next        = req.target_address;
                    hold_next        = req.repeated_start;
                    irq_next         = 1'b1;
                    res.start_issued = 1'b1;
                end
            end
            REQ_EVENT: begin
                // flags are handled in order; later flags see earlier updates
                if (irq_reg) begin
                    if (fl[FLAG_SB]) begin
                        if (state_next == ST_BUSY_TX) begin
                            res.data_write = 1'b1;
                            res.data_value = {peer_next, 1'b0};
                        end else if (state_next == ST_BUSY_RX) begin
                            res.data_write = 1'b1;
                            res.data_value = {peer_next, 1'b1};
                        end
                    end
                    if (fl[FLAG_ADDR] && req.is_master && state_next == ST_BUSY_RX
                        && rx_tot_next == len_t'(1)) begin
                        ack_next = 1'b0;
                    end
                    if (fl[FLAG_BTF] && fl[FLAG_TXE] && state_next == ST_BUSY_TX
                        && tx_rem_next == '0) begin
                        res.stop_issued = !hold_next;
                        tx_rem_next     = '0;
                        irq_next        = 1'b0;
                        state_next      = ST_READY;
                        if (ack_restore_reg) begin
                            ack_next = 1'b1;
                        end
                        res.notify_mask[NOTE_TX_DONE] = 1'b1;
                    end
                    if (fl[FLAG_STOPF]) begin
                        res.notify_mask[NOTE_STOP] = 1'b1;
                    end
                    if (fl[FLAG_TXE]) begin
                        if (req.is_master) begin
                            if (state_next == ST_BUSY_TX && tx_rem_next != '0) begin
                                res.data_write = 1'b1;
                                res.data_value = req.tx_byte;
                                res.tx_taken   = 1'b1;
                                tx_rem_next    = tx_rem_next - len_t'(1);
                            end
                        end else if (req.is_transmitter) begin
                            res.notify_mask[NOTE_SLV_SEND] = 1'b1;
                        end
                    end
                    if (fl[FLAG_RXNE]) begin
                        if (state_next == ST_BUSY_RX && req.is_master) begin
                            if (rx_tot_next != '0) begin
                                if (rx_tot_next > len_t'(1)
                                    && 32'(rx_rem_next) == 32'd2) begin
                                    ack_next = 1'b0;
                                end
                                res.rx_valid = 1'b1;
                                res.rx_data  = req.rx_byte;
                                if (rx_rem_next != '0) begin
                                    rx_rem_next = rx_rem_next - len_t'(1);
                                end
                            end
                            if (rx_rem_next == '0) begin
                                res.stop_issued = 1'b1;
                                rx_tot_next     = '0;
                                irq_next        = 1'b0;
                                state_next      = ST_READY;
                                if (ack_restore_reg) begin
                                    ack_next = 1'b1;
                                end
                                res.notify_mask[NOTE_RX_DONE] = 1'b1;
                            end
                        end else if (!req.is_transmitter) begin
                            res.notify_mask[NOTE_SLV_RECV] = 1'b1;
                        end
                    end
                end
            end
            REQ_ERROR: begin
                if (irq_reg) begin
                    res.error_mask = fl[4:0];
                end
            end
            default: ;
        endcase

        res.ack_level = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_READY;
            peer_reg        <= '0;
            tx_rem_reg      <= '0;
            rx_rem_reg      <= '0;
            rx_tot_reg      <= '0;
            hold_reg        <= 1'b0;
            irq_reg         <= 1'b0;
            ack_reg         <= 1'b0;
            ack_restore_reg <= 1'b1;
        end else begin
            if (advance) begin
                state_reg  <= state_next;
                peer_reg   <= peer_next;
                tx_rem_reg <= tx_rem_next;
                rx_rem_reg <= rx_rem_next;
                rx_tot_reg <= rx_tot_next;
                hold_reg   <= hold_next;
                irq_reg    <= irq_next;
                ack_reg    <= ack_next;
            end
            if (cfg_we) begin
                ack_restore_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/i2cseq_out_stage.sv =====
// Result register stage feeding the result channel.
module i2cseq_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  i2cseq_pkg::result_t  res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cseq_pkg::result_t  res_q
);
    import i2cseq_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign m_valid = valid_reg;
    assign res_q   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/i2c_master_irq_transfer_sequencer.sv =====
// Top level of the interrupt-driven I2C master transfer sequencer.
//
//   channel   direction  handshake          contents
//   s_*       in         s_valid/s_ready    begin, status event or error event request
//   m_*       out        m_valid/m_ready    one result per request
//   cfg_*     in         cfg_we (no wait)   ack_restore bit
//
// Each request lands in the input register, is decoded in one combinational
// pass against the state registers and lands in the result register, so a new
// request can be taken every cycle while m_ready is high.
// m_valid rises once the request has moved from the input register into the
// result register; a stalled result holds it in the input register.
// Reset (aresetn low, synchronous) empties both stages, puts the sequencer in
// ready with interrupts off, ACK low and ack_restore set.
// A stalled result holds the pipe: s_ready drops only when both stages are full.
module i2c_master_irq_transfer_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [15:0] s_transfer_length,
    input  logic [6:0] s_target_address,
    input  logic       s_repeated_start,
    input  logic [5:0] s_flag_bits,
    input  logic       s_is_master,
    input  logic       s_is_transmitter,
    input  logic [7:0] s_tx_byte,
    input  logic [7:0] s_rx_byte,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_prior_status,
    output logic       m_start_issued,
    output logic       m_data_write,
    output logic [7:0] m_data_value,
    output logic       m_tx_taken,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_data,
    output logic       m_ack_level,
    output logic       m_stop_issued,
    output logic [4:0] m_notify_mask,
    output logic [4:0] m_error_mask
);
    import i2cseq_pkg::*;

    req_t    in_req;
    req_t    req_q;
    logic    req_valid;
    logic    advance;
    result_t res;
    result_t res_q;

    // pack the request fields
    always_comb begin
        in_req.req_type        = req_kind_t'(s_req_type);
        in_req.transfer_length = s_transfer_length;
        in_req.target_address  = s_target_address;
        in_req.repeated_start  = s_repeated_start;
        in_req.flag_bits       = s_flag_bits;
        in_req.is_master       = s_is_master;
        in_req.is_transmitter  = s_is_transmitter;
        in_req.tx_byte         = s_tx_byte;
        in_req.rx_byte         = s_rx_byte;
    end

    // a held request moves on whenever the result register is free or draining
    assign advance = req_valid && (!m_valid || m_ready);

    i2cseq_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_req    (in_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req_q     (req_q)
    );

    // state update and result decode happen in the same cycle as advance
    i2cseq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .req       (req_q),
        .res       (res)
    );

    i2cseq_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .res_q   (res_q)
    );

    // unpack the result fields
    assign m_prior_status = res_q.prior_status;
    assign m_start_issued = res_q.start_issued;
    assign m_data_write   = res_q.data_write;
    assign m_data_value   = res_q.data_value;
    assign m_tx_taken     = res_q.tx_taken;
    assign m_rx_valid     = res_q.rx_valid;
    assign m_rx_data      = res_q.rx_data;
    assign m_ack_level    = res_q.ack_level;
    assign m_stop_issued  = res_q.stop_issued;
    assign m_notify_mask  = res_q.notify_mask;
    assign m_error_mask   = res_q.error_mask;

    // a start is only ever issued from the ready state
    a_start_from_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_issued |-> m_prior_status == PRIOR_READY)
        else $error("start issued while busy");

    // a consumed transmit byte always goes to the data register
    a_taken_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_taken |-> m_data_write)
        else $error("tx byte taken without data write");

    // input side stalls only when both stages are full and the output is blocked
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> req_valid && m_valid && !m_ready)
        else $error("request stalled with room in pipe");

    // a result is loaded in the cycle after its request advances
    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced request lost");

endmodule

// ===== tb/tb_i2c_master_irq_transfer_sequencer.sv =====
// Self-checking testbench for the interrupt-driven I2C master transfer sequencer.
module tb_i2c_master_irq_transfer_sequencer;
    import i2cseq_pkg::*;

    // Random part: four phases of this many requests each.
    localparam int PHASE_ITEMS = 400;
    // Cycles to let pass after the last result before a config write or the end.
    localparam int SETTLE_CYCLES = 4;

    // Status flag masks built from the package bit positions.
    localparam logic [5:0] F_SB    = 6'(1 << FLAG_SB);
    localparam logic [5:0] F_ADDR  = 6'(1 << FLAG_ADDR);
    localparam logic [5:0] F_BTF   = 6'(1 << FLAG_BTF);
    localparam logic [5:0] F_STOPF = 6'(1 << FLAG_STOPF);
    localparam logic [5:0] F_TXE   = 6'(1 << FLAG_TXE);
    localparam logic [5:0] F_RXNE  = 6'(1 << FLAG_RXNE);
    localparam logic [5:0] F_ALL   = 6'h3F;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type        = '0;
    logic [15:0] s_transfer_length = '0;
    logic [6:0]  s_target_address  = '0;
    logic        s_repeated_start  = 1'b0;
    logic [5:0]  s_flag_bits       = '0;
    logic        s_is_master       = 1'b0;
    logic        s_is_transmitter  = 1'b0;
    logic [7:0]  s_tx_byte         = '0;
    logic [7:0]  s_rx_byte         = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_prior_status;
    logic        m_start_issued;
    logic        m_data_write;
    logic [7:0]  m_data_value;
    logic        m_tx_taken;
    logic        m_rx_valid;
    logic [7:0]  m_rx_data;
    logic        m_ack_level;
    logic        m_stop_issued;
    logic [4:0]  m_notify_mask;
    logic [4:0]  m_error_mask;

    always #5 aclk = ~aclk;

    i2c_master_irq_transfer_sequencer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_transfer_length (s_transfer_length),
        .s_target_address  (s_target_address),
        .s_repeated_start  (s_repeated_start),
        .s_flag_bits       (s_flag_bits),
        .s_is_master       (s_is_master),
        .s_is_transmitter  (s_is_transmitter),
        .s_tx_byte         (s_tx_byte),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_prior_status    (m_prior_status),
        .m_start_issued    (m_start_issued),
        .m_data_write      (m_data_write),
        .m_data_value      (m_data_value),
        .m_tx_taken        (m_tx_taken),
        .m_rx_valid        (m_rx_valid),
        .m_rx_data         (m_rx_data),
        .m_ack_level       (m_ack_level),
        .m_stop_issued     (m_stop_issued),
        .m_notify_mask     (m_notify_mask),
        .m_error_mask      (m_error_mask)
    );

    // ------------------------------------------------------------------
    // Sequencer model state, reset values. xfer_code uses the reported
    // state codes (ready / busy receive / busy transmit).
    // ------------------------------------------------------------------
    logic [1:0] xfer_code     = PRIOR_READY;
    logic [6:0] peer_addr     = '0;
    len_t       tx_left       = '0;
    len_t       rx_left       = '0;
    len_t       rx_len        = '0;
    logic       hold_stop     = 1'b0;   // repeated start: no stop after transmit
    logic       irq_on        = 1'b0;
    logic       ack_q         = 1'b0;
    logic       ack_restore_q = 1'b1;

    result_t    pending_results[$];     // one expected result per accepted request
    int         mismatches = 0;
    bit         idle_on    = 1'b1;      // random gaps on both channels

    // Transfer close: interrupts off, back to ready, ACK restored if enabled.
    function automatic void close_transfer();
        irq_on    = 1'b0;
        xfer_code = PRIOR_READY;
        if (ack_restore_q)
            ack_q = 1'b1;
    endfunction

    // Expected result of one request; advances the model state.
    function automatic result_t transfer_result(req_t r);
        result_t    o;
        logic       busy;
        logic [5:0] f;
        o    = '0;
        f    = r.flag_bits;
        o.prior_status = xfer_code;
        busy = (xfer_code == PRIOR_BUSY_RX) || (xfer_code == PRIOR_BUSY_TX);
        case (r.req_type)
            REQ_BEGIN_TX, REQ_BEGIN_RX: begin
                // a begin while busy is dropped, only prior_status and ack_level are reported
                if (!busy) begin
                    if (r.req_type == REQ_BEGIN_TX) begin
                        xfer_code = PRIOR_BUSY_TX;
                        tx_left   = r.transfer_length;
                    end else begin
                        xfer_code = PRIOR_BUSY_RX;
                        rx_left   = r.transfer_length;
                        rx_len    = r.transfer_length;
                    end
                    peer_addr      = r.target_address;
                    hold_stop      = r.repeated_start;
                    o.start_issued = 1'b1;
                    irq_on         = 1'b1;
                end
            end
            REQ_EVENT: begin
                // enable sampled once: governs every flag even after a close
                if (irq_on) begin
                    if (f[FLAG_SB]) begin
                        if (xfer_code == PRIOR_BUSY_TX) begin
                            o.data_write = 1'b1;
                            o.data_value = {peer_addr, 1'b0};
                        end else if (xfer_code == PRIOR_BUSY_RX) begin
                            o.data_write = 1'b1;
                            o.data_value = {peer_addr, 1'b1};
                        end
                    end
                    // single-byte read: NACK the only byte
                    if (f[FLAG_ADDR] && r.is_master && xfer_code == PRIOR_BUSY_RX
                        && rx_len == 1)
                        ack_q = 1'b0;
                    if (f[FLAG_BTF] && f[FLAG_TXE] && xfer_code == PRIOR_BUSY_TX
                        && tx_left == 0) begin
                        if (!hold_stop)
                            o.stop_issued = 1'b1;
                        close_transfer();
                        o.notify_mask[NOTE_TX_DONE] = 1'b1;
                    end
                    if (f[FLAG_STOPF])
                        o.notify_mask[NOTE_STOP] = 1'b1;
                    if (f[FLAG_TXE]) begin
                        if (r.is_master) begin
                            if (xfer_code == PRIOR_BUSY_TX && tx_left != 0) begin
                                o.data_write = 1'b1;
                                o.data_value = r.tx_byte;   // overrides the address value when SB is set too
                                o.tx_taken   = 1'b1;
                                tx_left      = tx_left - 1'b1;
                            end
                        end else if (r.is_transmitter) begin
                            o.notify_mask[NOTE_SLV_SEND] = 1'b1;
                        end
                    end
                    if (f[FLAG_RXNE]) begin
                        if (xfer_code == PRIOR_BUSY_RX && r.is_master) begin
                            if (rx_len >= 1) begin
                                // second-to-last byte of a multi-byte read
                                if (rx_len > 1 && rx_left == 2)
                                    ack_q = 1'b0;
                                o.rx_valid = 1'b1;
                                o.rx_data  = r.rx_byte;
                                if (rx_left != 0)
                                    rx_left = rx_left - 1'b1;
                            end
                            // closes once no bytes are left; a zero-length read closes on its first RXNE
                            if (rx_left == 0) begin
                                o.stop_issued = 1'b1;
                                rx_len        = '0;
                                close_transfer();
                                o.notify_mask[NOTE_RX_DONE] = 1'b1;
                            end
                        end else if (!r.is_transmitter) begin
                            o.notify_mask[NOTE_SLV_RECV] = 1'b1;
                        end
                    end
                end
            end
            REQ_ERROR: begin
                if (irq_on)
                    o.error_mask = r.flag_bits[4:0];
            end
            default: ;
        endcase
        o.ack_level = ack_q;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Drive one request, hold it until taken, then log its expected result.
    // A typed-in result, where given, replaces the model's answer.
    task automatic push_req(req_t r, bit typed, result_t want);
        result_t got;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= r.req_type;
        s_transfer_length <= r.transfer_length;
        s_target_address  <= r.target_address;
        s_repeated_start  <= r.repeated_start;
        s_flag_bits       <= r.flag_bits;
        s_is_master       <= r.is_master;
        s_is_transmitter  <= r.is_transmitter;
        s_tx_byte         <= r.tx_byte;
        s_rx_byte         <= r.rx_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = transfer_result(r);
        pending_results.push_back(typed ? want : got);
    endtask

    // Sender stops until every expected result is back, then settles.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the pipe empty.
    task automatic write_ack_restore(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        ack_restore_q  = v;
    endtask

    function automatic req_t mk_req(req_kind_t kind, logic [15:0] len, logic [6:0] addr,
                                    logic rs, logic [5:0] flags, logic master,
                                    logic trans, logic [7:0] txb, logic [7:0] rxb);
        req_t r;
        r.req_type        = kind;
        r.transfer_length = len;
        r.target_address  = addr;
        r.repeated_start  = rs;
        r.flag_bits       = flags;
        r.is_master       = master;
        r.is_transmitter  = trans;
        r.tx_byte         = txb;
        r.rx_byte         = rxb;
        return r;
    endfunction

    // Random request steered by the model state: mostly the event that moves
    // the current transfer on (with stray flags at times), some noise and errors.
    function automatic req_t random_req();
        req_t r;
        int   roll;
        r = mk_req(req_kind_t'(2'($urandom_range(0, 3))), 16'($urandom), 7'($urandom),
                   1'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom), 8'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            // noise; an accepted begin keeps a short length so it can finish
            if ((r.req_type == REQ_BEGIN_TX || r.req_type == REQ_BEGIN_RX)
                && xfer_code == PRIOR_READY)
                r.transfer_length = 16'($urandom_range(0, 6));
        end else if (roll < 17) begin
            r.req_type = REQ_ERROR;
        end else begin
            case (xfer_code)
                PRIOR_BUSY_TX: begin
                    r.req_type       = REQ_EVENT;
                    r.is_master      = 1'b1;
                    r.is_transmitter = 1'b1;
                    r.flag_bits      = (tx_left != 0) ? F_TXE : (F_BTF | F_TXE);
                    if ($urandom_range(0, 3) == 0)
                        r.flag_bits |= 6'($urandom);
                end
                PRIOR_BUSY_RX: begin
                    r.req_type       = REQ_EVENT;
                    r.is_master      = 1'b1;
                    r.is_transmitter = 1'b0;
                    r.flag_bits      = F_RXNE;
                    if ($urandom_range(0, 3) == 0)
                        r.flag_bits |= 6'($urandom);
                end
                default: begin
                    r.req_type = $urandom_range(0, 1) ? REQ_BEGIN_TX : REQ_BEGIN_RX;
                    if ($urandom_range(0, 19) == 0)
                        r.transfer_length = 16'($urandom_range(7, 48));
                    else
                        r.transfer_length = 16'($urandom_range(0, 6));
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts on m_ready, then field checks
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        if (!idle_on)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 17);
        m_ready <= (stall_left == 0);
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("prior_status", want.prior_status, m_prior_status);
                check_field("start_issued", want.start_issued, m_start_issued);
                check_field("data_write",   want.data_write,   m_data_write);
                check_field("data_value",   want.data_value,   m_data_value);
                check_field("tx_taken",     want.tx_taken,     m_tx_taken);
                check_field("rx_valid",     want.rx_valid,     m_rx_valid);
                check_field("rx_data",      want.rx_data,      m_rx_data);
                check_field("ack_level",    want.ack_level,    m_ack_level);
                check_field("stop_issued",  want.stop_issued,  m_stop_issued);
                check_field("notify_mask",  want.notify_mask,  m_notify_mask);
                check_field("error_mask",   want.error_mask,   m_error_mask);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: request, typed flag, typed result
    // ------------------------------------------------------------------
    req_t    dir_req[$];
    bit      dir_typed[$];
    result_t dir_want[$];

    task automatic add_row(req_t r, bit typed, result_t want);
        dir_req.push_back(r);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    initial begin
        // interrupts off after reset: events and errors do nothing
        add_row(mk_req(REQ_EVENT, 16'h0000, 7'h00, 1'b0, F_ALL, 1'b1, 1'b0, 8'h00, 8'h00),
                1'b1, '{PRIOR_READY, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00,
                        1'b0, 1'b0, 5'h00, 5'h00});
        add_row(mk_req(REQ_ERROR, 16'hFFFF, 7'h7F, 1'b1, F_ALL, 1'b1, 1'b1, 8'hFF, 8'hFF),
                1'b1, '{PRIOR_READY, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00,
                        1'b0, 1'b0, 5'h00, 5'h00});
        // zero-length transmit to the top address
        add_row(mk_req(REQ_BEGIN_TX, 16'h0000, 7'h7F, 1'b0, 6'h00, 1'b1, 1'b1, 8'h00, 8'h00),
                1'b1, '{PRIOR_READY, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00,
                        1'b0, 1'b0, 5'h00, 5'h00});
        // begin while busy is dropped
        add_row(mk_req(REQ_BEGIN_RX, 16'hFFFF, 7'h00, 1'b1, F_ALL, 1'b0, 1'b0, 8'hFF, 8'hFF),
                1'b1, '{PRIOR_BUSY_TX, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00,
                        1'b0, 1'b0, 5'h00, 5'h00});
        // all error flags; the top flag bit is not an error
        add_row(mk_req(REQ_ERROR, 16'h0000, 7'h00, 1'b0, F_ALL, 1'b0, 1'b0, 8'h00, 8'h00),
                1'b1, '{PRIOR_BUSY_TX, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00,
                        1'b0, 1'b0, 5'h00, 5'h1F});
        // SB with TXE and nothing left to send, then BTF+TXE closes at once
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_SB | F_TXE, 1'b1, 1'b1, 8'hA5, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_BTF | F_TXE, 1'b1, 1'b1, 8'h5A, 8'h00), 0, '0);
        // zero-length receive: first RXNE delivers nothing and closes
        add_row(mk_req(REQ_BEGIN_RX, 0, 7'h55, 1'b0, 6'h00, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_SB | F_ADDR, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_RXNE, 1'b1, 1'b0, 8'h00, 8'hC3), 0, '0);
        // two-byte transmit with repeated start; SB and TXE together
        add_row(mk_req(REQ_BEGIN_TX, 2, 7'h12, 1'b1, 6'h00, 1'b1, 1'b1, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_SB | F_TXE, 1'b1, 1'b1, 8'h81, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_TXE, 1'b1, 1'b1, 8'hFF, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_TXE, 1'b1, 1'b1, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_BTF | F_TXE | F_STOPF, 1'b1, 1'b1,
                       8'h00, 8'h00), 0, '0);
        // one-byte receive: ADDR clears ACK
        add_row(mk_req(REQ_BEGIN_RX, 1, 7'h40, 1'b0, 6'h00, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_ADDR, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_RXNE, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        // three-byte receive with slave-mode events and an error in between
        add_row(mk_req(REQ_BEGIN_RX, 3, 7'h01, 1'b0, 6'h00, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_RXNE, 1'b1, 1'b0, 8'h00, 8'hFF), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_RXNE | F_STOPF, 1'b1, 1'b0, 8'h00, 8'h3C),
                0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_TXE | F_RXNE, 1'b0, 1'b1, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_TXE | F_RXNE, 1'b0, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_ERROR, 0, 0, 1'b0, F_ALL, 1'b1, 1'b0, 8'h00, 8'h00), 0, '0);
        add_row(mk_req(REQ_EVENT, 0, 0, 1'b0, F_RXNE, 1'b1, 1'b0, 8'h00, 8'h5A), 0, '0);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        req_t r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_ack_restore(1'b1);
        idle_on = 1'b1;
        foreach (dir_req[i])
            push_req(dir_req[i], dir_typed[i], dir_want[i]);

        // ACK restore alternates off/on; the odd phases run without gaps,
        // the last of them closing the run
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            write_ack_restore(phase[0]);
            idle_on = (phase[0] == 1'b0);
            repeat (PHASE_ITEMS) begin
                r = random_req();
                push_req(r, 1'b0, '0);
            end
        end
        drain_results();

        if (mismatches == 0)
            $display("PASS i2c_master_irq_transfer_sequencer");
        else
            $display("FAIL i2c_master_irq_transfer_sequencer");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("FAIL i2c_master_irq_transfer_sequencer");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cseq_pkg.sv
rtl/i2cseq_in_stage.sv
rtl/i2cseq_core.sv
rtl/i2cseq_out_stage.sv
rtl/i2c_master_irq_transfer_sequencer.sv
tb/tb_i2c_master_irq_transfer_sequencer.sv
